### rtl/lwc_pkg.sv
package lwc_pkg;

    // Internal widths, sized for the widest coordinate format (20-bit Q11.8).
    localparam int EXT_W   = 21;  // eye - target, up - eye, point - eye
    localparam int VEC_W   = 40;  // vector under normalization, cross products
    localparam int W_W     = 23;  // pre-scaled vector component
    localparam int BASIS_W = 19;  // Q2.16 basis component
    localparam int MUL_W   = 23;
    localparam int PROD_W  = 46;
    localparam int SUM2_W  = 45;
    localparam int SQX_W   = 62;
    localparam int ROOT_W  = 31;
    localparam int REM_W   = 35;
    localparam int DIVN_W  = 47;
    localparam int DIVR_W  = 32;
    localparam int CNT_W   = 6;
    localparam int SHIFT_W = 6;
    localparam int CAM_W   = 24;
    localparam int ACC_W   = 42;

    localparam logic [VEC_W-1:0]  NORM_LIMIT = 40'd2097152;
    localparam logic [DIVN_W-1:0] UNIT_Q     = 47'd65536;
    localparam logic [SHIFT_W-1:0] JC_SHIFT  = 6'd16;

    typedef enum logic [1:0] {
        REG_EYE    = 2'd0,
        REG_TARGET = 2'd1,
        REG_UP     = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_LOAD_K,
        ST_MAX,
        ST_SCAN,
        ST_RND,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_STORE,
        ST_X_MUL,
        ST_X_ACC,
        ST_JC_RND,
        ST_READY
    } basis_state_t;

    typedef struct packed {
        logic                    ready;
        logic                    degenerate;
        logic [2:0][BASIS_W-1:0] ic;
        logic [2:0][BASIS_W-1:0] jc;
        logic [2:0][BASIS_W-1:0] kc;
    } basis_t;

    // Divide by 2^s, rounding half away from zero.
    function automatic logic signed [VEC_W-1:0] shr_round(
        input logic signed [VEC_W-1:0] v,
        input logic [SHIFT_W-1:0]      s
    );
        logic [VEC_W-1:0] mag;
        logic [VEC_W-1:0] rnd;
        logic [VEC_W-1:0] res;
        mag = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
        rnd = (s == '0) ? '0 : (VEC_W'(1) << (s - 1'b1));
        res = (mag + rnd) >> s;
        return v[VEC_W-1] ? $signed(-res) : $signed(res);
    endfunction

    // Operand selection for the six products of a cross product.
    function automatic logic [1:0] cross_a_idx(input logic [2:0] p);
        logic [1:0] r;
        case (p)
            3'd0: r = 2'd1;
            3'd1: r = 2'd2;
            3'd2: r = 2'd2;
            3'd3: r = 2'd0;
            3'd4: r = 2'd0;
            3'd5: r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cross_b_idx(input logic [2:0] p);
        logic [1:0] r;
        case (p)
            3'd0: r = 2'd2;
            3'd1: r = 2'd1;
            3'd2: r = 2'd0;
            3'd3: r = 2'd2;
            3'd4: r = 2'd1;
            3'd5: r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/lwc_basis.sv
module lwc_basis
    import lwc_pkg::*;
#(
    parameter int COORD_BITS = 20
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [3*COORD_BITS-1:0] eye_point,
    input  logic [3*COORD_BITS-1:0] target_point,
    input  logic [3*COORD_BITS-1:0] up_point,
    output basis_t                  basis
);

    basis_state_t state_reg, state_next;

    logic                     phase_reg;
    logic                     degen_reg;
    logic [1:0]               idx_reg;
    logic [2:0]               p_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [SHIFT_W-1:0]       shift_reg;
    logic [VEC_W-1:0]         a_reg;
    logic signed [VEC_W-1:0]  v_reg  [3];
    logic signed [W_W-1:0]    w_reg  [3];
    logic signed [BASIS_W-1:0] kc_reg [3];
    logic signed [BASIS_W-1:0] ic_reg [3];
    logic signed [BASIS_W-1:0] jc_reg [3];
    logic signed [PROD_W-1:0] prod_reg;
    logic [SUM2_W-1:0]        s2_reg;
    logic [SQX_W-1:0]         sqx_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DIVN_W-1:0]        divn_reg;
    logic [DIVR_W-1:0]        divr_reg;

    logic signed [EXT_W-1:0]  k_c   [3];
    logic signed [EXT_W-1:0]  vup_c [3];
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [VEC_W-1:0]         mag_v [3];
    logic [VEC_W-1:0]         a_max;
    logic [REM_W-1:0]         sq_rem_sh, sq_trial;
    logic [DIVR_W-1:0]        dv_rem_sh;
    logic                     dv_ge;
    logic [1:0]               xa, xb;
    logic [W_W-1:0]           w_mag;
    logic [DIVN_W-1:0]        q_clamp;
    logic [BASIS_W-1:0]       q_u;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            k_c[i] = EXT_W'($signed(eye_point[i*COORD_BITS +: COORD_BITS]))
                   - EXT_W'($signed(target_point[i*COORD_BITS +: COORD_BITS]));
            vup_c[i] = EXT_W'($signed(up_point[i*COORD_BITS +: COORD_BITS]))
                     - EXT_W'($signed(eye_point[i*COORD_BITS +: COORD_BITS]));
            mag_v[i] = v_reg[i][VEC_W-1] ? VEC_W'(-v_reg[i]) : VEC_W'(v_reg[i]);
        end
        a_max = mag_v[0];
        if (mag_v[1] > a_max) a_max = mag_v[1];
        if (mag_v[2] > a_max) a_max = mag_v[2];
    end

    // Shared arithmetic: one multiplier, one root bit and one quotient bit a cycle.
    assign mul_p     = mul_a * mul_b;
    assign sq_rem_sh = {rem_reg[REM_W-3:0], sqx_reg[SQX_W-1 -: 2]};
    assign sq_trial  = {2'b00, root_reg, 2'b01};
    assign dv_rem_sh = {divr_reg[DIVR_W-2:0], divn_reg[DIVN_W-1]};
    assign dv_ge     = dv_rem_sh >= {1'b0, root_reg};
    assign w_mag     = w_reg[idx_reg][W_W-1] ? W_W'(-w_reg[idx_reg]) : W_W'(w_reg[idx_reg]);
    assign q_clamp   = (divn_reg > UNIT_Q) ? UNIT_Q : divn_reg;
    assign q_u       = w_reg[idx_reg][W_W-1] ? BASIS_W'(-q_clamp) : BASIS_W'(q_clamp);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD_K:    state_next = ST_MAX;
            ST_MAX:       state_next = (a_max == '0) ? ST_READY : ST_SCAN;
            ST_SCAN:      state_next = (a_reg >= NORM_LIMIT) ? ST_SCAN : ST_RND;
            ST_RND:       state_next = ST_SQ_MUL;
            ST_SQ_MUL:    state_next = ST_SQ_ACC;
            ST_SQ_ACC:    state_next = (idx_reg == 2'd2) ? ST_SQRT_INIT : ST_SQ_MUL;
            ST_SQRT_INIT: state_next = ST_SQRT;
            ST_SQRT:      state_next = (cnt_reg == CNT_W'(ROOT_W - 1)) ? ST_DIV_INIT : ST_SQRT;
            ST_DIV_INIT:  state_next = ST_DIV;
            ST_DIV:       state_next = (cnt_reg == CNT_W'(DIVN_W - 1)) ? ST_DIV_STORE : ST_DIV;
            ST_DIV_STORE: state_next = (idx_reg == 2'd2) ? ST_X_MUL : ST_DIV_INIT;
            ST_X_MUL:     state_next = ST_X_ACC;
            ST_X_ACC: begin
                if (p_reg != 3'd5) begin
                    state_next = ST_X_MUL;
                end else begin
                    state_next = phase_reg ? ST_JC_RND : ST_MAX;
                end
            end
            ST_JC_RND:    state_next = ST_READY;
            ST_READY:     state_next = ST_READY;
            default:      state_next = ST_LOAD_K;
        endcase
        if (start) state_next = ST_LOAD_K;
    end

    // Outputs and multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        xa    = cross_a_idx(p_reg);
        xb    = cross_b_idx(p_reg);
        case (state_reg)
            ST_SQ_MUL: begin
                mul_a = w_reg[idx_reg];
                mul_b = w_reg[idx_reg];
            end
            ST_X_MUL: begin
                mul_a = phase_reg ? MUL_W'(kc_reg[xa]) : MUL_W'(vup_c[xa]);
                mul_b = phase_reg ? MUL_W'(ic_reg[xb]) : MUL_W'(kc_reg[xb]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        basis.ready      = (state_reg == ST_READY);
        basis.degenerate = degen_reg;
        for (int i = 0; i < 3; i++) begin
            basis.ic[i] = ic_reg[i];
            basis.jc[i] = jc_reg[i];
            basis.kc[i] = kc_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD_K;
            degen_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (!start) begin
                case (state_reg)
                    ST_LOAD_K: begin
                        for (int i = 0; i < 3; i++) v_reg[i] <= VEC_W'(k_c[i]);
                        phase_reg <= 1'b0;
                        degen_reg <= 1'b0;
                    end
                    ST_MAX: begin
                        a_reg     <= a_max;
                        shift_reg <= '0;
                        if (a_max == '0) degen_reg <= 1'b1;
                    end
                    ST_SCAN: begin
                        if (a_reg >= NORM_LIMIT) begin
                            a_reg     <= a_reg >> 1;
                            shift_reg <= shift_reg + 1'b1;
                        end
                    end
                    ST_RND: begin
                        for (int i = 0; i < 3; i++) begin
                            w_reg[i] <= W_W'(shr_round(v_reg[i], shift_reg));
                        end
                        idx_reg <= '0;
                        s2_reg  <= '0;
                    end
                    ST_SQ_MUL: prod_reg <= mul_p;
                    ST_SQ_ACC: begin
                        s2_reg <= s2_reg + prod_reg[SUM2_W-1:0];
                        if (idx_reg != 2'd2) idx_reg <= idx_reg + 1'b1;
                    end
                    ST_SQRT_INIT: begin
                        sqx_reg  <= {1'b0, s2_reg, 16'b0};
                        rem_reg  <= '0;
                        root_reg <= '0;
                        cnt_reg  <= '0;
                    end
                    ST_SQRT: begin
                        sqx_reg <= sqx_reg << 2;
                        cnt_reg <= cnt_reg + 1'b1;
                        if (sq_rem_sh >= sq_trial) begin
                            rem_reg  <= sq_rem_sh - sq_trial;
                            root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                        end else begin
                            rem_reg  <= sq_rem_sh;
                            root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                        end
                        if (cnt_reg == CNT_W'(ROOT_W - 1)) idx_reg <= '0;
                    end
                    ST_DIV_INIT: begin
                        divn_reg <= (DIVN_W'(w_mag) << 24) + DIVN_W'(root_reg >> 1);
                        divr_reg <= '0;
                        cnt_reg  <= '0;
                    end
                    ST_DIV: begin
                        divr_reg <= dv_ge ? dv_rem_sh - {1'b0, root_reg} : dv_rem_sh;
                        divn_reg <= {divn_reg[DIVN_W-2:0], dv_ge};
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                    ST_DIV_STORE: begin
                        if (phase_reg) begin
                            ic_reg[idx_reg] <= q_u;
                        end else begin
                            kc_reg[idx_reg] <= q_u;
                        end
                        if (idx_reg == 2'd2) begin
                            p_reg <= '0;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    ST_X_MUL: prod_reg <= mul_p;
                    ST_X_ACC: begin
                        if (p_reg[0]) begin
                            v_reg[p_reg[2:1]] <= v_reg[p_reg[2:1]] - VEC_W'(prod_reg);
                        end else begin
                            v_reg[p_reg[2:1]] <= VEC_W'(prod_reg);
                        end
                        if (p_reg != 3'd5) begin
                            p_reg <= p_reg + 1'b1;
                        end else begin
                            phase_reg <= 1'b1;
                        end
                    end
                    ST_JC_RND: begin
                        for (int i = 0; i < 3; i++) begin
                            jc_reg[i] <= BASIS_W'(shr_round(v_reg[i], JC_SHIFT));
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

### rtl/lookat_world_to_camera_top.sv
// An accepted input word passes through stages S1 to S4 to its result word on m_*.
// Throughput: one word per cycle with the camera basis built and m_ready high.
// After reset and after every configuration write the basis unit rebuilds the
// basis (two bit-serial square roots, six bit-serial divides), and s_ready
// stays low until it is done. Reset is synchronous, active low, and loads
// eye (0,0,0), target (0,0,-1) and up (0,1,0).
module lookat_world_to_camera_top
    import lwc_pkg::*;
#(
    parameter int COORD_BITS = 20,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_addr,
    input  logic [3*COORD_BITS-1:0]      cfg_wdata,
    // world-space point in
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_world_x,
    input  logic signed [COORD_BITS-1:0] s_world_y,
    input  logic signed [COORD_BITS-1:0] s_world_z,
    // camera-space point out
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [CAM_W-1:0]      m_cam_x,
    output logic signed [CAM_W-1:0]      m_cam_y,
    output logic signed [CAM_W-1:0]      m_cam_z,
    output logic                         m_degenerate
);

    // One unit in the coordinate format; drops to zero if it does not fit.
    localparam logic [COORD_BITS-1:0] ONE_C = COORD_BITS'(1) << FRAC_BITS;
    localparam logic [COORD_BITS-1:0] NEG_ONE_C = ~ONE_C + 1'b1;
    localparam logic [3*COORD_BITS-1:0] TARGET_RESET =
        {NEG_ONE_C, {COORD_BITS{1'b0}}, {COORD_BITS{1'b0}}};
    localparam logic [3*COORD_BITS-1:0] UP_RESET =
        {{COORD_BITS{1'b0}}, ONE_C, {COORD_BITS{1'b0}}};

    logic [3*COORD_BITS-1:0] eye_reg, target_reg, up_reg;
    basis_t                  bs;

    // Configuration registers. Any write restarts the basis build.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eye_reg    <= '0;
            target_reg <= TARGET_RESET;
            up_reg     <= UP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_EYE:    eye_reg    <= cfg_wdata;
                REG_TARGET: target_reg <= cfg_wdata;
                REG_UP:     up_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    lwc_basis #(
        .COORD_BITS(COORD_BITS)
    ) u_basis (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (cfg_wr_en),
        .eye_point    (eye_reg),
        .target_point (target_reg),
        .up_point     (up_reg),
        .basis        (bs)
    );

    // Point pipeline: S1 subtract eye, S2 nine products, S3 three sums,
    // S4 round and saturate into the output register. All stages advance
    // together; a stall at the output holds every stage.
    logic                      adv;
    logic                      v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic signed [EXT_W-1:0]   d1_reg [3];
    logic signed [VEC_W-1:0]   p2_reg [3][3];
    logic signed [ACC_W-1:0]   s3_reg [3];
    logic signed [CAM_W-1:0]   cam_reg [3];
    logic                      degen_reg;
    logic signed [COORD_BITS-1:0] world_c [3];
    logic signed [BASIS_W-1:0] basis_c [3][3];
    logic [ACC_W-1:0]          mag_c [3];
    logic [ACC_W-1:0]          rmag_c [3];
    logic signed [CAM_W-1:0]   cam_next [3];

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && bs.ready;

    always_comb begin
        world_c[0] = s_world_x;
        world_c[1] = s_world_y;
        world_c[2] = s_world_z;
        for (int i = 0; i < 3; i++) begin
            basis_c[0][i] = $signed(bs.ic[i]);
            basis_c[1][i] = $signed(bs.jc[i]);
            basis_c[2][i] = $signed(bs.kc[i]);
        end
        // Round half away from zero by 2^16, then clamp to 24 bits.
        for (int j = 0; j < 3; j++) begin
            mag_c[j]  = s3_reg[j][ACC_W-1] ? ACC_W'(-s3_reg[j]) : ACC_W'(s3_reg[j]);
            rmag_c[j] = (mag_c[j] + ACC_W'(32768)) >> 16;
            if (s3_reg[j][ACC_W-1]) begin
                cam_next[j] = (rmag_c[j] > ACC_W'(8388608)) ?
                              CAM_W'(24'sh800000) : CAM_W'(-rmag_c[j]);
            end else begin
                cam_next[j] = (rmag_c[j] > ACC_W'(8388607)) ?
                              CAM_W'(24'sh7FFFFF) : CAM_W'(rmag_c[j]);
            end
            if (bs.degenerate) cam_next[j] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid && s_ready;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                d1_reg[i] <= EXT_W'(world_c[i])
                           - EXT_W'($signed(eye_reg[i*COORD_BITS +: COORD_BITS]));
            end
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    p2_reg[j][i] <= basis_c[j][i] * d1_reg[i];
                end
                s3_reg[j] <= ACC_W'(p2_reg[j][0]) + ACC_W'(p2_reg[j][1])
                           + ACC_W'(p2_reg[j][2]);
                cam_reg[j] <= cam_next[j];
            end
            degen_reg <= bs.degenerate;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cam_x      = cam_reg[0];
    assign m_cam_y      = cam_reg[1];
    assign m_cam_z      = cam_reg[2];
    assign m_degenerate = degen_reg;

    // A configuration write always drops s_ready while the basis rebuilds.
    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("input accepted right after configuration write");

    // A degenerate result carries zero coordinates.
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |-> (m_cam_x == '0 && m_cam_y == '0 && m_cam_z == '0))
        else $error("degenerate word with nonzero coordinates");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule
